// File: rtl/core/lss_pkg.sv
// lss_pkg: shared types and constants for the line selection sorter
// no dependencies
`timescale 1ns / 1ps
package lss_pkg;
  localparam int MaxLinesDef  = 128;
  localparam int LineBytesDef = 512;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       end_of_line;
    logic       end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_last;
    logic       set_last;
    logic       nothing_left;
    logic       data_dropped;
  } out_item_t;
endpackage

// File: rtl/core/line_selection_sorter_core.sv
// line_selection_sorter_core: top level of the line selection sorter
// depends on lss_pkg
`timescale 1ns / 1ps
// Lines are loaded one byte per item and sorted in ascending unsigned-byte
// order, where a shorter prefix ranks first. Loads can follow back to back.
// A read item goes through accept and order table lookup, then length fetch
// and store read, then the result register. A read with nothing left
// answers in the cycle after it is accepted. in is not ready while a result
// waits on out. The item that ends the set then runs a selection sort
// through a single shared byte comparator. The sort first sets up the order
// table for N lines, then runs N*(N-1)/2 compares, each reading the two
// lines byte position by byte position through the store read port. in is
// not ready during the sort.
// The line store is one byte memory addressed by line index and byte
// position, each padded to a power of two (MAX_LINES*LINE_BYTES bytes at the
// defaults), with a single read port; no clearing pass follows reset.
module line_selection_sorter_core #(
  parameter int MAX_LINES  = lss_pkg::MaxLinesDef,
  parameter int LINE_BYTES = lss_pkg::LineBytesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lss_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lss_pkg::out_item_t out_data
);
  import lss_pkg::*;

  localparam int LW = $clog2(MAX_LINES);
  localparam int PW = $clog2(LINE_BYTES);
  localparam int TW = $clog2(MAX_LINES + 1);
  localparam int AW = LW + PW;

  // sequencer states
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_RDW  = 10'b0000000100,
    S_INIT = 10'b0000001000,
    S_OUTR = 10'b0000010000,
    S_INNR = 10'b0000100000,
    S_CA   = 10'b0001000000,
    S_CB   = 10'b0010000000,
    S_CMP  = 10'b0100000000,
    S_SWAP = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [7:0]    store_mem [2**AW];
  logic [PW-1:0] len_mem   [MAX_LINES];
  logic [LW-1:0] ord_mem   [MAX_LINES];

  logic [TW-1:0] total_r;
  logic [TW-1:0] rline_r;
  logic [PW-1:0] rpos_r;
  logic [PW-1:0] lpos_r;
  logic          ended_r;
  logic          ovf_r;
  logic          done_r;

  // sort indices and comparator state
  logic [TW-1:0] i_r, j_r, best_r;
  logic [LW-1:0] li_r, lb_r;          // line ids at j and best
  logic [PW-1:0] la_r, lbl_r;         // lengths
  logic [PW-1:0] k_r;                 // byte cursor
  logic [7:0]    ca_r;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata_r;
  logic          sub_r;               // comparator fetch sub-step

  out_item_t obuf_r;
  logic      ovalid_r;

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = obuf_r;

  logic acc;
  assign acc = in_valid && in_ready;

  // effective set state when loading after a finished sort
  logic          clr;
  logic [TW-1:0] tot_e;
  logic [PW-1:0] lpos_e;
  logic          ended_e;
  logic          ovf_e;
  assign clr     = acc && in_data.operation == OpLoad && done_r;
  assign tot_e   = clr ? '0 : total_r;
  assign lpos_e  = clr ? '0 : lpos_r;
  assign ended_e = clr ? 1'b0 : ended_r;
  assign ovf_e   = clr ? 1'b0 : ovf_r;

  // what a load item does to the current line
  logic          set_full;
  logic          take_byte;
  logic          drop_byte;
  logic          close_line;
  logic [PW-1:0] lpos_a;
  logic          ended_a;
  assign set_full   = tot_e >= TW'(MAX_LINES);
  assign take_byte  = !set_full && !ended_e && in_data.data_byte != 8'd0 &&
                      lpos_e < PW'(LINE_BYTES - 1);
  assign drop_byte  = set_full || (!ended_e && in_data.data_byte != 8'd0 &&
                      lpos_e >= PW'(LINE_BYTES - 1));
  assign close_line = in_data.end_of_line || in_data.end_of_set;
  assign lpos_a     = take_byte ? lpos_e + 1'b1 : lpos_e;
  assign ended_a    = ended_e || (!set_full && in_data.data_byte == 8'd0);

  logic [LW-1:0] rid_r;
  logic [PW-1:0] rlen_r;

  // single store read port
  always_ff @(posedge clk) begin
    rdata_r <= store_mem[raddr];
  end

  always_comb begin
    raddr = {rid_r, rpos_r};
    if (state_r == S_CA || (state_r == S_CB && !sub_r)) raddr = {li_r, k_r};
    if (state_r == S_CB && sub_r) raddr = {lb_r, k_r};
  end

  logic [PW-1:0] minl;
  assign minl = (la_r < lbl_r) ? la_r : lbl_r;

  // compare step result
  logic cmp_end, cmp_less;
  always_comb begin
    cmp_end  = 1'b0;
    cmp_less = 1'b0;
    if (k_r >= minl || !sub_r) begin
      cmp_end  = 1'b1;
      cmp_less = la_r < lbl_r;
    end else if (ca_r != rdata_r) begin
      cmp_end  = 1'b1;
      cmp_less = ca_r < rdata_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_data.operation == OpRead && done_r && rline_r < total_r)
          state_nxt = S_RD;
        else if (acc && in_data.operation == OpLoad && in_data.end_of_set)
          state_nxt = S_INIT;
      end
      S_RD:   state_nxt = S_RDW;
      S_RDW:  state_nxt = S_IDLE;
      S_INIT: state_nxt = (i_r + 1'b1 >= total_r) ? S_OUTR : S_INIT;
      S_OUTR: state_nxt = (i_r + 1'b1 < total_r) ? S_INNR : S_IDLE;
      S_INNR: state_nxt = (j_r < total_r) ? S_CA : S_SWAP;
      S_CA:   state_nxt = (k_r < minl) ? S_CB : S_CMP;
      S_CB:   state_nxt = sub_r ? S_CMP : S_CB;
      S_CMP:  state_nxt = cmp_end ? S_INNR : S_CA;
      S_SWAP: state_nxt = S_OUTR;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      total_r  <= '0;
      rline_r  <= '0;
      rpos_r   <= '0;
      lpos_r   <= '0;
      ended_r  <= 1'b0;
      ovf_r    <= 1'b0;
      done_r   <= 1'b0;
      ovalid_r <= 1'b0;
      sub_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc && in_data.operation == OpLoad) begin
            if (clr) done_r <= 1'b0;
            if (clr || in_data.end_of_set) begin
              rline_r <= '0;
              rpos_r  <= '0;
            end
            if (take_byte) store_mem[{tot_e[LW-1:0], lpos_e}] <= in_data.data_byte;
            ovf_r   <= ovf_e || drop_byte;
            lpos_r  <= close_line ? '0 : lpos_a;
            ended_r <= close_line ? 1'b0 : ended_a;
            // a closed line is kept only while the table has room
            if (close_line && !set_full) begin
              len_mem[tot_e[LW-1:0]] <= lpos_a;
              total_r <= tot_e + 1'b1;
            end else total_r <= tot_e;
            if (in_data.end_of_set) i_r <= '0;
          end else if (acc) begin
            obuf_r <= '{8'd0, 1'b0, 1'b0, 1'b1, ovf_r};
            if (done_r && rline_r < total_r) begin
              rid_r  <= ord_mem[rline_r[LW-1:0]];
            end else ovalid_r <= 1'b1;
          end
        end
        S_RD: rlen_r <= len_mem[rid_r];
        S_RDW: begin
          ovalid_r <= 1'b1;
          obuf_r.nothing_left <= 1'b0;
          if (rlen_r == '0 || rpos_r + 1'b1 >= rlen_r) begin
            obuf_r.out_byte  <= (rlen_r == '0) ? 8'd0 : rdata_r;
            obuf_r.line_last <= 1'b1;
            obuf_r.set_last  <= (rline_r + 1'b1 == total_r);
            rline_r <= rline_r + 1'b1;
            rpos_r  <= '0;
          end else begin
            obuf_r.out_byte  <= rdata_r;
            obuf_r.line_last <= 1'b0;
            obuf_r.set_last  <= 1'b0;
            rpos_r <= rpos_r + 1'b1;
          end
        end
        S_INIT: begin
          ord_mem[i_r[LW-1:0]] <= i_r[LW-1:0];
          if (i_r + 1'b1 >= total_r) begin
            i_r    <= '0;
            done_r <= 1'b1;
          end else i_r <= i_r + 1'b1;
        end
        S_OUTR: begin
          best_r <= i_r;
          j_r    <= i_r + 1'b1;
          lb_r   <= ord_mem[i_r[LW-1:0]];
          lbl_r  <= len_mem[ord_mem[i_r[LW-1:0]]];
        end
        S_INNR: begin
          if (j_r < total_r) begin
            li_r  <= ord_mem[j_r[LW-1:0]];
            la_r  <= len_mem[ord_mem[j_r[LW-1:0]]];
            k_r   <= '0;
            sub_r <= 1'b0;
          end
        end
        S_CA: sub_r <= 1'b0;
        S_CB: begin
          if (!sub_r) sub_r <= 1'b1;
          else ca_r <= rdata_r;
        end
        S_CMP: begin
          sub_r <= 1'b0;
          if (cmp_end) begin
            if (cmp_less) begin
              best_r <= j_r;
              lb_r   <= li_r;
              lbl_r  <= la_r;
            end
            j_r <= j_r + 1'b1;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_SWAP: begin
          if (best_r != i_r) begin
            ord_mem[i_r[LW-1:0]]    <= lb_r;
            ord_mem[best_r[LW-1:0]] <= ord_mem[i_r[LW-1:0]];
          end
          i_r <= i_r + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: tb/sv/testbench.sv
// testbench: self-checking bench for line_selection_sorter_core
// depends on lss_pkg and the core rtl; holds its own line-sort predictor
`timescale 1ns / 1ps
module testbench;
  import lss_pkg::*;

  localparam int Lines = MaxLinesDef;
  localparam int Bytes = LineBytesDef;

  typedef bit [7:0] text_t[$];

  // predicts sorted read-back bytes and checks results in order
  class line_sort_scoreboard;
    bit [7:0]    line_bytes[Lines * Bytes];
    int unsigned line_len[Lines];
    int unsigned rank_tab[Lines];
    int unsigned n_lines, rd_line, rd_pos, load_pos;
    bit          dropped, sorted, content_stop;
    int          errors;
    out_item_t   sorted_bytes_q[$];

    function bit precedes(int unsigned a, int unsigned b);
      int unsigned n;
      n = (line_len[a] < line_len[b]) ? line_len[a] : line_len[b];
      for (int unsigned i = 0; i < n; i++) begin
        if (line_bytes[a * Bytes + i] != line_bytes[b * Bytes + i])
          return line_bytes[a * Bytes + i] < line_bytes[b * Bytes + i];
      end
      return line_len[a] < line_len[b];
    endfunction

    function void rank_lines();
      int unsigned best, t;
      for (int unsigned i = 0; i < n_lines; i++) rank_tab[i] = i;
      for (int unsigned i = 0; i + 1 < n_lines; i++) begin
        best = i;
        for (int unsigned j = i + 1; j < n_lines; j++)
          if (precedes(rank_tab[j], rank_tab[best])) best = j;
        t = rank_tab[i];
        rank_tab[i] = rank_tab[best];
        rank_tab[best] = t;
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t   e;
      int unsigned idx;
      if (it.operation == OpLoad) begin
        if (sorted) begin
          n_lines = 0; rd_line = 0; rd_pos = 0; dropped = 0;
          sorted = 0; load_pos = 0; content_stop = 0;
        end
        if (n_lines >= Lines) dropped = 1;
        else if (!content_stop) begin
          if (it.data_byte == 8'd0) content_stop = 1;
          else if (load_pos < Bytes - 1) begin
            line_bytes[n_lines * Bytes + load_pos] = it.data_byte;
            load_pos++;
          end else dropped = 1;
        end
        if (it.end_of_line || it.end_of_set) begin
          if (n_lines < Lines) begin
            line_len[n_lines] = load_pos;
            n_lines++;
          end
          load_pos = 0;
          content_stop = 0;
        end
        if (it.end_of_set) begin
          rank_lines();
          sorted = 1; rd_line = 0; rd_pos = 0;
        end
        return;
      end
      e = '0;
      e.data_dropped = dropped;
      if (!sorted || rd_line >= n_lines) e.nothing_left = 1;
      else begin
        idx = rank_tab[rd_line];
        if (line_len[idx] == 0) e.line_last = 1;
        else begin
          e.out_byte = line_bytes[idx * Bytes + rd_pos];
          e.line_last = (rd_pos + 1 >= line_len[idx]);
        end
        if (e.line_last) begin
          e.set_last = (rd_line + 1 == n_lines);
          rd_line++;
          rd_pos = 0;
        end else rd_pos++;
      end
      sorted_bytes_q.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (sorted_bytes_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = sorted_bytes_q.pop_front();
      if (got.out_byte !== e.out_byte) begin
        $display("%0t: out_byte exp %h got %h", $time, e.out_byte, got.out_byte);
        errors++;
      end
      if (got.line_last !== e.line_last) begin
        $display("%0t: line_last exp %b got %b", $time, e.line_last, got.line_last);
        errors++;
      end
      if (got.set_last !== e.set_last) begin
        $display("%0t: set_last exp %b got %b", $time, e.set_last, got.set_last);
        errors++;
      end
      if (got.nothing_left !== e.nothing_left) begin
        $display("%0t: nothing_left exp %b got %b", $time, e.nothing_left,
                 got.nothing_left);
        errors++;
      end
      if (got.data_dropped !== e.data_dropped) begin
        $display("%0t: data_dropped exp %b got %b", $time, e.data_dropped,
                 got.data_dropped);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_data;

  line_sort_scoreboard sb = new();
  in_item_t  stim_q[$];
  int        set_lines, set_bytes;   // read-back length of the set being built
  bit        calm;                   // no idling while set
  bit        stim_done = 0;

  always #2 clk = ~clk;

  line_selection_sorter_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // accepted items and results are seen at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_item(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // mostly short gaps, a few long ones
  function int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // pushes one line; zero bytes inside the content are passed through as is
  task push_line(input text_t txt, input bit close_set, input bit eol_flag);
    in_item_t    it;
    int unsigned len;
    bit          stop;
    if (txt.size() == 0) txt.push_back(8'd0);
    len = 0;
    stop = 0;
    foreach (txt[i]) begin
      it = '0;
      it.operation = OpLoad;
      it.data_byte = txt[i];
      if (i == txt.size() - 1) begin
        it.end_of_set = close_set;
        it.end_of_line = close_set ? eol_flag : 1'b1;
      end
      stim_q.push_back(it);
      if (txt[i] == 8'd0) stop = 1;
      else if (!stop && len < Bytes - 1) len++;
    end
    if (set_lines < Lines) begin
      set_lines++;
      set_bytes += (len == 0) ? 1 : len;
    end
  endtask

  task push_reads(input int n);
    in_item_t it;
    repeat (n) begin
      it.operation = OpRead;
      it.data_byte = 8'($urandom_range(0, 255));
      it.end_of_line = 1'($urandom_range(0, 1));
      it.end_of_set = 1'($urandom_range(0, 1));
      stim_q.push_back(it);
    end
  endtask

  // small alphabet makes ties and shared prefixes common
  function text_t rand_text(int max_len);
    text_t t;
    int    r;
    repeat ($urandom_range(0, max_len)) begin
      r = $urandom_range(0, 99);
      if (r < 55) t.push_back(8'(8'h61 + $urandom_range(0, 2)));
      else if (r < 65) t.push_back(8'h01);
      else if (r < 75) t.push_back(8'hff);
      else if (r < 79) t.push_back(8'h00);
      else t.push_back(8'($urandom_range(1, 255)));
    end
    return t;
  endfunction

  task rand_set(input int n);
    text_t prev, cur;
    set_lines = 0;
    set_bytes = 0;
    for (int i = 0; i < n; i++) begin
      cur = (i > 0 && $urandom_range(0, 3) == 0) ? prev : rand_text(6);
      push_line(cur, i == n - 1, 1'($urandom_range(0, 1)));
      prev = cur;
    end
  endtask

  task build_stimulus();
    text_t t;
    // read before any set was sorted
    push_reads(1);
    // directed set: empty line, prefix pair, zero byte mid-line, byte extremes
    set_lines = 0;
    set_bytes = 0;
    t = {8'h61, 8'h62};              push_line(t, 0, 1);
    t = {};                           push_line(t, 0, 1);
    t = {8'hff, 8'h80};              push_line(t, 0, 1);
    t = {8'h61};                      push_line(t, 0, 1);
    t = {8'h61, 8'h00, 8'h7a};       push_line(t, 0, 1);
    t = {8'h01};                      push_line(t, 1, 0);
    push_reads(set_bytes + 2);       // read past the end of the set
    // load after sorting starts a new set: a single line closed by end_of_set
    set_lines = 0;
    set_bytes = 0;
    t = {8'h7f};                      push_line(t, 1, 1);
    push_reads(set_bytes + 1);

    // long line: bytes past the line capacity are dropped
    set_lines = 0;
    set_bytes = 0;
    t = {};
    repeat (Bytes + 8) t.push_back(8'($urandom_range(1, 255)));
    push_line(t, 0, 1);
    t = rand_text(4);
    push_line(t, 1, 1);
    push_reads(16);

    // too many lines: lines past the table size are dropped
    set_lines = 0;
    set_bytes = 0;
    for (int i = 0; i < Lines + 3; i++) begin
      t = {8'(8'h61 + $urandom_range(0, 3))};
      push_line(t, i == Lines + 2, 1);
    end
    push_reads(24);

    // random sets, mostly well formed
    while (stim_q.size() < 800) begin
      if ($urandom_range(0, 7) == 0) push_reads($urandom_range(1, 2));
      rand_set(($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                          : $urandom_range(7, 16));
      if ($urandom_range(0, 5) == 0) push_reads($urandom_range(0, set_bytes));
      else push_reads(set_bytes + $urandom_range(0, 2));
    end
  endtask

  // input side: valid held until accepted, changes only at the falling edge
  task drive_items();
    int g;
    foreach (stim_q[i]) begin
      if (i % 97 == 0) calm = ($urandom_range(0, 3) == 0);
      g = gap_len();
      if (g > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_data <= stim_q[i];
      do @(posedge clk); while (!in_ready);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // result side: random stalls of varying length
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = gap_len();
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drive_items();
    while (sb.sorted_bytes_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  // watchdog: well beyond the slowest correct run, sort of the full table included
  initial begin
    #8000000;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
